/* hdl/hes_pkg.sv */
// Shared constants for the heightmap elevation sampler.
// No dependencies; used by the channel interfaces and the core.
package hes_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int COORD_W    = 16;
  localparam int INT_W      = COORD_W - FRAC_BITS;
  localparam int HEIGHT_W   = 24;
  localparam int DIM_W      = 9;
  localparam int GRID_MAX_W = 256;
  localparam int GRID_MAX_H = 256;
  localparam int COL_W      = $clog2(GRID_MAX_W);
  localparam int ROW_W      = $clog2(GRID_MAX_H);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int MEM_DEPTH  = GRID_MAX_W * GRID_MAX_H;
  localparam int CFG_IDX_W  = 1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(GRID_MAX_W);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(GRID_MAX_H);

endpackage

/* hdl/hes_in_if.sv */
// Request channel of the heightmap elevation sampler: valid/ready plus item.
// Depends on hes_pkg for field widths.
interface hes_in_if
  import hes_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [COORD_W-1:0]         x_coord;
  logic [COORD_W-1:0]         y_coord;
  logic signed [HEIGHT_W-1:0] height_value;

  modport source (output valid, func, x_coord, y_coord, height_value, input ready);
  modport sink   (input valid, func, x_coord, y_coord, height_value, output ready);
endinterface

/* hdl/hes_out_if.sv */
// Result channel of the heightmap elevation sampler: valid/ready plus result.
// Depends on hes_pkg for field widths.
interface hes_out_if
  import hes_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] elevation;
  logic                       out_of_range;

  modport source (output valid, elevation, out_of_range, input ready);
  modport sink   (input valid, elevation, out_of_range, output ready);
endinterface

/* hdl/heightmap_elevation_sampler_core.sv */
// Heightmap store with triangle interpolation of fixed-point queries.
// Depends on hes_pkg, hes_in_if and hes_out_if.
//
//   channel  dir  modport           payload
//   req_i    in   hes_in_if.sink     func, x_coord, y_coord, height_value
//   rsp_o    out  hes_out_if.source  elevation, out_of_range
//   cfg      in   plain write        cfg_we_i, cfg_idx_i, cfg_data_i
//
// A write or a flagged query goes from S_IDLE straight to S_DONE, which loads the result register.
// An in-range query passes S_RD, S_MUL and S_SUM before S_DONE loads it: reads of the four
// corners through the single read port, one multiply, one sum, one handoff. Requests are taken only in S_IDLE.
// Reset is asynchronous; the height memory is not cleared and needs no pass.
// A stalled result holds in the output register while the next beat is taken; a new
// result waits in S_DONE until that register frees up.
module heightmap_elevation_sampler_core
  import hes_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  hes_in_if.sink               req_i,
  hes_out_if.source            rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_SUM,
    S_DONE
  } state_e;

  state_e                     state_q;
  logic [DIM_W-1:0]           gw_q, gh_q;
  logic [COL_W-1:0]           ix_q;
  logic [ROW_W-1:0]           iy_q;
  logic [FRAC_BITS:0]         fx_q, fy_q;
  logic [2:0]                 cnt_q;
  logic signed [HEIGHT_W-1:0] z_q [4];
  logic signed [HEIGHT_W+FRAC_BITS+2:0] pa_q, pb_q;
  logic signed [HEIGHT_W-1:0] res_q;
  logic                       res_oor_q;
  logic                       out_valid_q;
  logic signed [HEIGHT_W-1:0] out_elev_q;
  logic                       out_oor_q;
  logic [HEIGHT_W-1:0]        mem_q [MEM_DEPTH];
  logic [HEIGHT_W-1:0]        rdata_q;

  // request decode
  logic                 accept;
  logic [INT_W-1:0]     ix_in, iy_in;
  logic [FRAC_BITS-1:0] fx_in, fy_in;
  logic [DIM_W-1:0]     ix_ext, iy_ext, gw_m1, gh_m1;
  logic                 wr_oor, q_oor, mem_we;
  logic                 adj_x, adj_y;

  assign accept = req_i.valid && req_i.ready;
  assign ix_in  = req_i.x_coord[COORD_W-1:FRAC_BITS];
  assign iy_in  = req_i.y_coord[COORD_W-1:FRAC_BITS];
  assign fx_in  = req_i.x_coord[FRAC_BITS-1:0];
  assign fy_in  = req_i.y_coord[FRAC_BITS-1:0];
  assign ix_ext = DIM_W'(ix_in);
  assign iy_ext = DIM_W'(iy_in);
  assign gw_m1  = gw_q - DIM_W'(1);
  assign gh_m1  = gh_q - DIM_W'(1);

  assign wr_oor = (ix_ext >= gw_q) || (iy_ext >= gh_q);
  assign q_oor  = (ix_ext > gw_m1) || (ix_ext == gw_m1 && fx_in != '0) ||
                  (iy_ext > gh_m1) || (iy_ext == gh_m1 && fy_in != '0);
  assign mem_we = accept && req_i.func == FUNC_WRITE && !wr_oor;

  // a zero fraction on a positive grid line moves to the previous cell at
  // fraction one; an exact grid point keeps its own cell
  assign adj_x = fx_in == '0 && ix_in != '0 && fy_in != '0;
  assign adj_y = fy_in == '0 && iy_in != '0 && fx_in != '0;

  assign req_i.ready = (state_q == S_IDLE);

  // corner order: (x,y), (x+1,y), (x+1,y+1), (x,y+1)
  logic [COL_W-1:0]  rd_col;
  logic [ROW_W-1:0]  rd_row;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [1:0]        zi;

  assign rd_col  = ix_q + COL_W'(cnt_q[0] ^ cnt_q[1]);
  assign rd_row  = iy_q + ROW_W'(cnt_q[1]);
  assign rd_addr = {rd_row, rd_col};
  assign wr_addr = {ROW_W'(iy_in), COL_W'(ix_in)};
  assign zi      = cnt_q[1:0] - 2'd1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= req_i.height_value;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // plane blend
  logic                                 lower;
  logic signed [HEIGHT_W:0]             da, db;
  logic [FRAC_BITS:0]                   wa, wb;
  logic signed [HEIGHT_W+FRAC_BITS+3:0] acc;
  logic                                 out_free;

  assign lower = fy_q < fx_q;
  assign da = lower ? (HEIGHT_W+1)'(z_q[1]) - (HEIGHT_W+1)'(z_q[0])
                    : (HEIGHT_W+1)'(z_q[3]) - (HEIGHT_W+1)'(z_q[0]);
  assign db = lower ? (HEIGHT_W+1)'(z_q[2]) - (HEIGHT_W+1)'(z_q[1])
                    : (HEIGHT_W+1)'(z_q[2]) - (HEIGHT_W+1)'(z_q[3]);
  assign wa = lower ? fx_q : fy_q;
  assign wb = lower ? fy_q : fx_q;
  assign acc = ((HEIGHT_W+FRAC_BITS+4)'(z_q[0]) <<< FRAC_BITS) +
               (HEIGHT_W+FRAC_BITS+4)'(pa_q) + (HEIGHT_W+FRAC_BITS+4)'(pb_q);
  assign out_free = !out_valid_q || rsp_o.ready;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi)      return hi;
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gw_q        <= DIM_MAX_W;
      gh_q        <= DIM_MAX_H;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_WIDTH:  gw_q <= clamp_dim(cfg_data_i, DIM_MAX_W);
          CFG_GRID_HEIGHT: gh_q <= clamp_dim(cfg_data_i, DIM_MAX_H);
          default: ;
        endcase
      end
      // load a finished beat, else drop the one the sink has taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ix_q  <= COL_W'(ix_in - INT_W'(adj_x));
            iy_q  <= ROW_W'(iy_in - INT_W'(adj_y));
            fx_q  <= adj_x ? (FRAC_BITS+1)'(1 << FRAC_BITS) : (FRAC_BITS+1)'(fx_in);
            fy_q  <= adj_y ? (FRAC_BITS+1)'(1 << FRAC_BITS) : (FRAC_BITS+1)'(fy_in);
            cnt_q <= '0;
            res_q <= '0;
            if (req_i.func == FUNC_WRITE) begin
              res_oor_q <= wr_oor;
              state_q   <= S_DONE;
            end else begin
              res_oor_q <= q_oor;
              state_q   <= q_oor ? S_DONE : S_RD;
            end
          end
        end
        S_RD: begin
          // issue reads on counts 0..3, catch each corner's data from rdata_q on counts 1..4
          if (cnt_q != 3'd0) begin
            z_q[zi] <= rdata_q;
          end
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          pa_q    <= da * $signed({1'b0, wa});
          pb_q    <= db * $signed({1'b0, wb});
          state_q <= S_SUM;
        end
        S_SUM: begin
          // an exact grid point returns its stored height untouched
          res_q   <= (fx_q == '0 && fy_q == '0) ? z_q[0] : acc[FRAC_BITS +: HEIGHT_W];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_elev_q <= res_q;
            out_oor_q  <= res_oor_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.elevation    = out_elev_q;
  assign rsp_o.out_of_range = out_oor_q;

  a_dims_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gw_q >= DIM_MIN && gw_q <= DIM_MAX_W && gh_q >= DIM_MIN && gh_q <= DIM_MAX_H)
    else $error("grid dimension register outside its clamp range");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.out_of_range) |-> rsp_o.elevation == '0)
    else $error("flagged beat carries a nonzero elevation");

  a_rd_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> cnt_q <= 3'd4)
    else $error("corner read counter overran");

  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (state_q == S_DONE && !res_oor_q))
    else $error("height write not followed by its result");

endmodule
